[rtl/core/ced_pkg.sv]
`timescale 1ns / 1ps

package ced_pkg;

    localparam int unsigned PIPE_DEPTH = 5;

    localparam logic [7:0] SPECIAL_MIN = 8'hC0;

    localparam logic [3:0] TAG_FALLBACK  = 4'd0;
    localparam logic [3:0] TAG_LONG_PRIM = 4'd1;
    localparam logic [3:0] TAG_LONG_SEC  = 4'd2;
    localparam logic [3:0] TAG_RESERVED  = 4'd3;
    localparam logic [3:0] TAG_LATIN     = 4'd4;
    localparam logic [3:0] TAG_BUILDER   = 4'd7;
    localparam logic [3:0] TAG_OFFSET    = 4'd14;
    localparam logic [3:0] TAG_IMPLICIT  = 4'd15;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FALLBACK = 2'd1;
    localparam logic [1:0] ST_LOOKUP   = 2'd2;
    localparam logic [1:0] ST_RESERVED = 2'd3;

    localparam logic [31:0] COMMON_SEC_TER = 32'h0500_0500;
    localparam logic [7:0]  COMMON_WEIGHT  = 8'h05;

    localparam logic [7:0] BYTE_MIN      = 8'd2;
    localparam logic [7:0] LO2_PLAIN     = 8'd2;
    localparam logic [7:0] LO2_COMP      = 8'd4;
    localparam logic [7:0] RADIX_PLAIN   = 8'd254;
    localparam logic [7:0] RADIX_COMP    = 8'd251;
    localparam logic [7:0] IMPL_DIV      = 8'd18;
    localparam logic [7:0] IMPL_MUL      = 8'd14;
    localparam logic [7:0] IMPL_LEAD     = 8'hFE;
    localparam logic [7:0] IMPL_LO3      = 8'd4;

    // reciprocals rounded up, exact floor for the operand widths used
    localparam int unsigned Q1_SHIFT = 36;
    localparam logic [28:0] RECIP_254_Q1 =
        29'(((64'd1 << 36) + 64'd253) / 64'd254);
    localparam int unsigned Q2_SHIFT = 29;
    localparam logic [21:0] RECIP_254_Q2 =
        22'(((64'd1 << 29) + 64'd253) / 64'd254);
    localparam logic [21:0] RECIP_251_Q2 =
        22'(((64'd1 << 29) + 64'd250) / 64'd251);
    localparam int unsigned Q18_SHIFT = 27;
    localparam logic [22:0] RECIP_18 =
        23'(((64'd1 << 27) + 64'd17) / 64'd18);
    localparam int unsigned QI_SHIFT = 25;
    localparam logic [17:0] RECIP_254_I =
        18'(((64'd1 << 25) + 64'd253) / 64'd254);

    typedef enum logic [1:0] {
        KIND_FIXED,
        KIND_RANGE,
        KIND_IMPLICIT
    } ced_kind_t;

    typedef struct packed {
        ced_kind_t   kind;
        logic [63:0] elem0;
        logic [63:0] elem1;
        logic        two;
        logic [1:0]  status;
        logic [3:0]  tag;
    } ced_meta_t;

endpackage

[rtl/core/collation_element_decoder.sv]
`timescale 1ns / 1ps

// channel   | ports                                   | handshake
// ----------+-----------------------------------------+------------------------------
// input     | trie_value, code_point, range_data      | taken when start & !busy
// result    | element, status, tag_seen, last         | valid for one cycle with done
//
// every item enters the pipe in the cycle it is taken; its first result
// appears with done after the five pipe stages and the output register
// a latin expansion gives a second result in the next cycle; while the first
// is shown busy is high and the whole pipe holds, so it costs one input slot
// every other item takes one input slot, so one item per cycle is sustained between holds
// rst_n clears the valid bits, done and the hold flag; the receiver cannot stall

module collation_element_decoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] trie_value,
    input  logic [20:0] code_point,
    input  logic [63:0] range_data,
    output logic        done,
    output logic [63:0] element,
    output logic [1:0]  status,
    output logic [3:0]  tag_seen,
    output logic        last
);

    localparam int unsigned Depth = ced_pkg::PIPE_DEPTH;

    logic                     accept;
    logic                     advance;
    ced_pkg::ced_meta_t       meta_in;
    ced_pkg::ced_meta_t       meta_reg [Depth];
    ced_pkg::ced_meta_t       meta_out;
    logic [Depth-1:0]         valid_reg;
    logic [Depth-1:0]         valid_next;
    logic                     pending_reg;
    logic                     pending_next;
    logic                     done_reg;
    logic                     done_next;
    logic [63:0]              element_reg;
    logic [63:0]              element_next;
    logic [63:0]              elem1_reg;
    logic [63:0]              elem1_next;
    logic [1:0]               status_reg;
    logic [1:0]               status_next;
    logic [3:0]               tag_reg;
    logic [3:0]               tag_next;
    logic                     last_reg;
    logic                     last_next;
    logic [31:0]              range_primary;
    logic [31:0]              implicit_primary;
    logic [63:0]              elem_sel;

    assign advance = !pending_reg;
    assign accept  = start && !pending_reg;

    ced_front u_front (
        .trie_value (trie_value),
        .meta       (meta_in)
    );

    ced_range u_range (
        .clk        (clk),
        .en         (advance),
        .code_point (code_point),
        .range_data (range_data),
        .primary    (range_primary)
    );

    ced_implicit u_implicit (
        .clk        (clk),
        .en         (advance),
        .code_point (code_point),
        .primary    (implicit_primary)
    );

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            meta_reg[0] <= meta_in;
            for (int i = 1; i < Depth; i++)
            begin
                meta_reg[i] <= meta_reg[i-1];
            end
        end
    end

    assign meta_out   = meta_reg[Depth-1];
    assign valid_next = advance ? {valid_reg[Depth-2:0], accept} : valid_reg;

    always_comb
    begin
        case (meta_out.kind)
            ced_pkg::KIND_RANGE:    elem_sel = {range_primary, ced_pkg::COMMON_SEC_TER};
            ced_pkg::KIND_IMPLICIT: elem_sel = {implicit_primary, ced_pkg::COMMON_SEC_TER};
            default:                elem_sel = meta_out.elem0;
        endcase
    end

    always_comb
    begin
        if (pending_reg)
        begin
            done_next    = 1'b1;
            element_next = elem1_reg;
            elem1_next   = elem1_reg;
            status_next  = status_reg;
            tag_next     = tag_reg;
            last_next    = 1'b1;
            pending_next = 1'b0;
        end
        else
        begin
            done_next    = valid_reg[Depth-1];
            element_next = elem_sel;
            elem1_next   = meta_out.elem1;
            status_next  = meta_out.status;
            tag_next     = meta_out.tag;
            last_next    = !meta_out.two;
            pending_next = valid_reg[Depth-1] && meta_out.two;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= '0;
            pending_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            valid_reg   <= valid_next;
            pending_reg <= pending_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        element_reg <= element_next;
        elem1_reg   <= elem1_next;
        status_reg  <= status_next;
        tag_reg     <= tag_next;
        last_reg    <= last_next;
    end

    assign busy     = pending_reg;
    assign done     = done_reg;
    assign element  = element_reg;
    assign status   = status_reg;
    assign tag_seen = tag_reg;
    assign last     = last_reg;

    // the hold for a second result lasts exactly one cycle
    a_hold_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> !busy)
        else $error("hold flag stayed set");

    // while holding, the first half of an expansion is on the result ports
    a_hold_shows_first: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> (done && !last && tag_seen == ced_pkg::TAG_LATIN))
        else $error("hold without a first expansion result");

    // a first half is always followed by its closing result
    a_second_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !last) |=> (done && last && $stable(tag_seen)))
        else $error("expansion second result missing");

    // a status other than ok carries an empty element
    a_status_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != ced_pkg::ST_OK) |-> (element == 64'd0 && last))
        else $error("status result carries an element");

endmodule

[rtl/core/ced_front.sv]
`timescale 1ns / 1ps

module ced_front (
    input  logic [31:0]       trie_value,
    output ced_pkg::ced_meta_t meta
);

    logic [3:0] tag;

    assign tag = trie_value[3:0];

    always_comb
    begin
        meta.kind   = ced_pkg::KIND_FIXED;
        meta.elem0  = '0;
        meta.elem1  = '0;
        meta.two    = 1'b0;
        meta.status = ced_pkg::ST_OK;
        meta.tag    = tag;
        if (trie_value[7:0] < ced_pkg::SPECIAL_MIN)
        begin
            meta.tag   = '0;
            meta.elem0 = {trie_value[31:16], 16'h0000, trie_value[15:8], 8'h00,
                          trie_value[7:0], 8'h00};
        end
        else
        begin
            case (tag)
                ced_pkg::TAG_FALLBACK:
                begin
                    meta.status = ced_pkg::ST_FALLBACK;
                end
                ced_pkg::TAG_LONG_PRIM:
                begin
                    meta.elem0 = {trie_value[31:8], 8'h00, ced_pkg::COMMON_SEC_TER};
                end
                ced_pkg::TAG_LONG_SEC:
                begin
                    meta.elem0 = {32'h0000_0000, trie_value[31:8], 8'h00};
                end
                ced_pkg::TAG_RESERVED, ced_pkg::TAG_BUILDER:
                begin
                    meta.status = ced_pkg::ST_RESERVED;
                end
                ced_pkg::TAG_LATIN:
                begin
                    meta.two   = 1'b1;
                    meta.elem0 = {trie_value[31:24], 24'h000000,
                                  ced_pkg::COMMON_WEIGHT, 8'h00, trie_value[23:16], 8'h00};
                    meta.elem1 = {32'h0000_0000, trie_value[15:8], 8'h00,
                                  ced_pkg::COMMON_WEIGHT, 8'h00};
                end
                ced_pkg::TAG_OFFSET:
                begin
                    meta.kind = ced_pkg::KIND_RANGE;
                end
                ced_pkg::TAG_IMPLICIT:
                begin
                    meta.kind = ced_pkg::KIND_IMPLICIT;
                end
                default:
                begin
                    meta.status = ced_pkg::ST_LOOKUP;
                end
            endcase
        end
    end

endmodule

[rtl/core/ced_range.sv]
`timescale 1ns / 1ps

module ced_range (
    input  logic        clk,
    input  logic        en,
    input  logic [20:0] code_point,
    input  logic [63:0] range_data,
    output logic [31:0] primary
);

    // stage 1: offset product and clamped base bytes
    logic [23:0] base_cp;
    logic [20:0] diff;
    logic [7:0]  lo2_in;
    logic [27:0] off_next;
    logic [7:0]  b3m2_next;
    logic [7:0]  b2m_next;

    logic [27:0] off_reg;
    logic [7:0]  b3m2_reg;
    logic [7:0]  b2m1_reg;
    logic        comp1_reg;
    logic [7:0]  lead1_reg;

    // stage 2: low byte operand
    logic [27:0] v2_reg;
    logic [7:0]  b2m2_reg;
    logic        comp2_reg;
    logic [7:0]  lead2_reg;

    // stage 3: quotient by 254
    logic [56:0] prod1;
    logic [20:0] q1_reg;
    logic [27:0] v3_reg;
    logic [7:0]  b2m3_reg;
    logic        comp3_reg;
    logic [7:0]  lead3_reg;

    // stage 4: low byte and middle operand
    logic [27:0] r1;
    logic [7:0]  low4_reg;
    logic [20:0] w4_reg;
    logic        comp4_reg;
    logic [7:0]  lead4_reg;

    // stage 5: quotient by the middle radix
    logic [21:0] recip2;
    logic [42:0] prod2;
    logic [13:0] q2_reg;
    logic [20:0] w5_reg;
    logic [7:0]  low5_reg;
    logic        comp5_reg;
    logic [7:0]  lead5_reg;

    logic [7:0]  radix_out;
    logic [7:0]  lo2_out;
    logic [20:0] r2;

    always_comb
    begin
        base_cp   = range_data[31:8];
        diff      = (24'(code_point) > base_cp) ? code_point - base_cp[20:0] : '0;
        off_next  = 28'(diff) * 28'(range_data[6:0]);
        b3m2_next = (range_data[47:40] < ced_pkg::BYTE_MIN) ? '0
                    : range_data[47:40] - ced_pkg::BYTE_MIN;
        lo2_in    = range_data[7] ? ced_pkg::LO2_COMP : ced_pkg::LO2_PLAIN;
        b2m_next  = (range_data[55:48] < lo2_in) ? '0 : range_data[55:48] - lo2_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            off_reg   <= off_next;
            b3m2_reg  <= b3m2_next;
            b2m1_reg  <= b2m_next;
            comp1_reg <= range_data[7];
            lead1_reg <= range_data[63:56];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            v2_reg    <= off_reg + 28'(b3m2_reg);
            b2m2_reg  <= b2m1_reg;
            comp2_reg <= comp1_reg;
            lead2_reg <= lead1_reg;
        end
    end

    assign prod1 = 57'(v2_reg) * 57'(ced_pkg::RECIP_254_Q1);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q1_reg    <= prod1[56:ced_pkg::Q1_SHIFT];
            v3_reg    <= v2_reg;
            b2m3_reg  <= b2m2_reg;
            comp3_reg <= comp2_reg;
            lead3_reg <= lead2_reg;
        end
    end

    assign r1 = v3_reg - 28'(q1_reg) * 28'(ced_pkg::RADIX_PLAIN);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            low4_reg  <= r1[7:0] + ced_pkg::BYTE_MIN;
            w4_reg    <= q1_reg + 21'(b2m3_reg);
            comp4_reg <= comp3_reg;
            lead4_reg <= lead3_reg;
        end
    end

    assign recip2 = comp4_reg ? ced_pkg::RECIP_251_Q2 : ced_pkg::RECIP_254_Q2;
    assign prod2  = 43'(w4_reg) * 43'(recip2);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q2_reg    <= prod2[42:ced_pkg::Q2_SHIFT];
            w5_reg    <= w4_reg;
            low5_reg  <= low4_reg;
            comp5_reg <= comp4_reg;
            lead5_reg <= lead4_reg;
        end
    end

    always_comb
    begin
        radix_out = comp5_reg ? ced_pkg::RADIX_COMP : ced_pkg::RADIX_PLAIN;
        lo2_out   = comp5_reg ? ced_pkg::LO2_COMP : ced_pkg::LO2_PLAIN;
        r2        = w5_reg - 21'(q2_reg) * 21'(radix_out);
        primary   = {lead5_reg + q2_reg[7:0], r2[7:0] + lo2_out, low5_reg, 8'h00};
    end

endmodule

[rtl/core/ced_implicit.sv]
`timescale 1ns / 1ps

module ced_implicit (
    input  logic        clk,
    input  logic        en,
    input  logic [20:0] code_point,
    output logic [31:0] primary
);

    logic [21:0] c1_reg;

    logic [44:0] prod18;
    logic [16:0] q18_2_reg;
    logic [21:0] c2_reg;

    logic [21:0] r18;
    logic [7:0]  b0_3_reg;
    logic [16:0] q18_3_reg;

    logic [34:0] prodi;
    logic [8:0]  qi4_reg;
    logic [16:0] q18_4_reg;
    logic [7:0]  b0_4_reg;

    logic [16:0] ri;
    logic [8:0]  qi5_reg;
    logic [7:0]  b1_5_reg;
    logic [7:0]  b0_5_reg;

    logic [8:0]  top_mod;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c1_reg <= 22'(code_point) + 22'd1;
        end
    end

    assign prod18 = 45'(c1_reg) * 45'(ced_pkg::RECIP_18);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q18_2_reg <= prod18[43:ced_pkg::Q18_SHIFT];
            c2_reg    <= c1_reg;
        end
    end

    assign r18 = c2_reg - 22'(q18_2_reg) * 22'(ced_pkg::IMPL_DIV);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b0_3_reg  <= 8'(r18[4:0]) * ced_pkg::IMPL_MUL + ced_pkg::BYTE_MIN;
            q18_3_reg <= q18_2_reg;
        end
    end

    assign prodi = 35'(q18_3_reg) * 35'(ced_pkg::RECIP_254_I);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            qi4_reg   <= prodi[33:ced_pkg::QI_SHIFT];
            q18_4_reg <= q18_3_reg;
            b0_4_reg  <= b0_3_reg;
        end
    end

    assign ri = q18_4_reg - 17'(qi4_reg) * 17'(ced_pkg::RADIX_PLAIN);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            qi5_reg  <= qi4_reg;
            b1_5_reg <= ri[7:0] + ced_pkg::BYTE_MIN;
            b0_5_reg <= b0_4_reg;
        end
    end

    always_comb
    begin
        top_mod = (qi5_reg >= 9'(ced_pkg::RADIX_COMP)) ? qi5_reg - 9'(ced_pkg::RADIX_COMP)
                  : qi5_reg;
        primary = {ced_pkg::IMPL_LEAD, top_mod[7:0] + ced_pkg::IMPL_LO3, b1_5_reg, b0_5_reg};
    end

endmodule

[bench/ced_element_checker.sv]
`timescale 1ns / 1ps

module ced_element_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [31:0] trie_value,
    input  logic [20:0] code_point,
    input  logic [63:0] range_data,
    input  logic        done,
    input  logic [63:0] element,
    input  logic [1:0]  status,
    input  logic [3:0]  tag_seen,
    input  logic        last,
    output int          mismatches,
    output int          pending,
    output int          results_checked
);

    localparam logic [31:0] RADIX_FULL       = 32'd254;
    localparam logic [31:0] RADIX_COMPRESSED = 32'd251;
    localparam logic [31:0] IMPLICIT_GROUPS  = 32'd18;
    localparam logic [31:0] IMPLICIT_SPACING = 32'd14;
    localparam logic [31:0] COMMON_PAIR      = 32'h0500_0500;
    localparam logic [7:0]  COMMON_BYTE      = 8'h05;

    typedef struct packed {
        logic [63:0] element;
        logic [1:0]  status;
        logic [3:0]  tag;
        logic        last;
    } decoded_ce_t;

    decoded_ce_t expected_elements[$];
    decoded_ce_t oldest;

    function automatic logic [31:0] stepped_primary(input logic [31:0] base,
                                                    input logic compressible,
                                                    input logic [31:0] offset);
        logic [31:0] third;
        logic [31:0] second;
        logic [31:0] lo2;
        logic [31:0] radix2;
        logic [31:0] acc;
        logic [31:0] prim;
        third = {24'h0, base[15:8]};
        second = {24'h0, base[23:16]};
        lo2 = compressible ? 32'd4 : 32'd2;
        radix2 = compressible ? RADIX_COMPRESSED : RADIX_FULL;
        if (third < 32'd2)
            third = 32'd2;
        if (second < lo2)
            second = lo2;
        acc = offset + third - 32'd2;
        prim = ((acc % RADIX_FULL) + 32'd2) << 8;
        acc = acc / RADIX_FULL + second - lo2;
        prim = prim | (((acc % radix2) + lo2) << 16);
        acc = acc / radix2;
        // lead byte wraps modulo 256
        return prim | ((base & 32'hFF00_0000) + (acc << 24));
    endfunction

    function automatic logic [31:0] range_primary(input logic [20:0] cp,
                                                  input logic [63:0] data);
        logic [31:0] base_cp;
        logic [31:0] offset;
        base_cp = {8'h0, data[31:8]};
        offset = 32'd0;
        if ({11'h0, cp} > base_cp)
            offset = ({11'h0, cp} - base_cp) * {25'h0, data[6:0]};
        return stepped_primary(data[63:32], data[7], offset);
    endfunction

    function automatic logic [31:0] implicit_primary(input logic [20:0] cp);
        logic [31:0] c;
        logic [31:0] prim;
        c = {11'h0, cp} + 32'd1;
        prim = 32'd2 + (c % IMPLICIT_GROUPS) * IMPLICIT_SPACING;
        c = c / IMPLICIT_GROUPS;
        prim = prim | ((32'd2 + c % RADIX_FULL) << 8);
        c = c / RADIX_FULL;
        prim = prim | ((32'd4 + c % RADIX_COMPRESSED) << 16);
        return prim | 32'hFE00_0000;
    endfunction

    function automatic void predict_elements(input logic [31:0] v, input logic [20:0] cp,
                                             input logic [63:0] data);
        decoded_ce_t ce;
        ce = '{element: 64'h0, status: ced_pkg::ST_OK, tag: v[3:0], last: 1'b1};
        if (v[7:6] != 2'b11)
        begin
            ce.tag = 4'h0;
            ce.element = {v[31:16], 16'h0, v[15:8], 8'h0, v[7:0], 8'h0};
        end
        else
        begin
            case (v[3:0])
                ced_pkg::TAG_FALLBACK:
                    ce.status = ced_pkg::ST_FALLBACK;
                ced_pkg::TAG_LONG_PRIM:
                    ce.element = {v[31:8], 8'h0, COMMON_PAIR};
                ced_pkg::TAG_LONG_SEC:
                    ce.element = {32'h0, v[31:8], 8'h0};
                ced_pkg::TAG_RESERVED, ced_pkg::TAG_BUILDER:
                    ce.status = ced_pkg::ST_RESERVED;
                ced_pkg::TAG_LATIN:
                begin
                    ce.element = {v[31:24], 24'h0, COMMON_BYTE, 8'h0, v[23:16], 8'h0};
                    ce.last = 1'b0;
                    expected_elements.push_back(ce);
                    ce.element = {32'h0, v[15:8], 8'h0, COMMON_BYTE, 8'h0};
                    ce.last = 1'b1;
                end
                ced_pkg::TAG_OFFSET:
                    ce.element = {range_primary(cp, data), COMMON_PAIR};
                ced_pkg::TAG_IMPLICIT:
                    ce.element = {implicit_primary(cp), COMMON_PAIR};
                default:
                    ce.status = ced_pkg::ST_LOOKUP;
            endcase
        end
        expected_elements.push_back(ce);
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
            begin
                results_checked++;
                if (expected_elements.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected result element %h status %0d tag %0d last %0d",
                                 $time, element, status, tag_seen, last);
                end
                else
                begin
                    oldest = expected_elements.pop_front();
                    if (oldest.element !== element || oldest.status !== status
                        || oldest.tag !== tag_seen || oldest.last !== last)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: mismatch: expected %h/%0d/%0d/%0d, got %h/%0d/%0d/%0d",
                                     $time, oldest.element, oldest.status, oldest.tag,
                                     oldest.last, element, status, tag_seen, last);
                    end
                end
            end
            if (start && !busy)
                predict_elements(trie_value, code_point, range_data);
            pending = expected_elements.size();
        end
    end

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [31:0] trie_value = 32'h0;
    logic [20:0] code_point = 21'h0;
    logic [63:0] range_data = 64'h0;
    logic        done;
    logic [63:0] element;
    logic [1:0]  status;
    logic [3:0]  tag_seen;
    logic        last;
    int          mismatches;
    int          pending;
    int          results_checked;
    int          idle_pct = 0;
    int          items_sent = 0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    collation_element_decoder u_dut (.*);

    ced_element_checker u_checker (.*);

    initial
    begin
        #2_000_000;
        $display("** collation_element_decoder: FAILED **");
        $finish;
    end

    task automatic send_item(input logic [31:0] v, input logic [20:0] cp,
                             input logic [63:0] data);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        trie_value <= v;
        code_point <= cp;
        range_data <= data;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic send_directed();
        send_item(32'h0000_0000, 21'h0, 64'h0);
        send_item(32'hFFFF_FFBF, 21'h1F_FFFF, '1);
        for (int t = 0; t < 16; t++)
            send_item({24'hFF_FFFF, 4'hF, 4'(t)}, 21'h10_FFFF, 64'h0);
        send_item({24'h0, 4'hC, ced_pkg::TAG_LATIN}, 21'h0, 64'h0);
        send_item({24'h0, 4'hC, ced_pkg::TAG_LONG_PRIM}, 21'h0, 64'h0);
        // code point below the range base
        send_item({24'h0, 4'hC, ced_pkg::TAG_OFFSET}, 21'h100,
                  {32'h5533_2100, 24'h00_0200, 1'b0, 7'd5});
        // base bytes below the usable minimum
        send_item({24'h0, 4'hC, ced_pkg::TAG_OFFSET}, 21'h10,
                  {32'h2000_0000, 24'h0, 1'b0, 7'd1});
        send_item({24'h0, 4'hC, ced_pkg::TAG_OFFSET}, 21'h3,
                  {32'h2001_0100, 24'h0, 1'b1, 7'd1});
        // base bytes at or above the usable maximum, carry into the next byte
        send_item({24'h0, 4'hC, ced_pkg::TAG_OFFSET}, 21'h0_FFFF,
                  {32'h30FF_FF00, 24'h0, 1'b1, 7'd127});
        // lead byte overflow
        send_item({24'h0, 4'hC, ced_pkg::TAG_OFFSET}, 21'h1F_FFFF,
                  {32'hFFFD_FD00, 24'h0, 1'b0, 7'd127});
        send_item({24'h0, 4'hC, ced_pkg::TAG_IMPLICIT}, 21'h0, 64'h0);
        send_item({24'h0, 4'hC, ced_pkg::TAG_IMPLICIT}, 21'h1F_FFFF, 64'h0);
    endtask

    task automatic send_random_item();
        logic [31:0] v;
        logic [20:0] cp;
        logic [63:0] data;
        logic [23:0] base_cp;
        int          pick;
        v = $urandom;
        cp = 21'($urandom);
        data = {$urandom, $urandom};
        base_cp = data[31:8];
        pick = $urandom_range(99);
        if (pick < 12)
        begin
            if (v[7:6] == 2'b11)
                v[6] = 1'b0;
        end
        else
        begin
            v[7:6] = 2'b11;
            if (pick < 27)
                ;
            else if (pick < 42)
                v[3:0] = ced_pkg::TAG_LATIN;
            else if (pick < 52)
            begin
                v[3:0] = ced_pkg::TAG_IMPLICIT;
                if ($urandom_range(1) == 1)
                    cp = 21'($urandom_range(21'h10_FFFF));
            end
            else
            begin
                v[3:0] = ced_pkg::TAG_OFFSET;
                case ($urandom_range(3))
                    0: data[47:40] = 8'($urandom_range(4));
                    1: data[55:48] = 8'($urandom_range(5));
                    2: data[55:40] = {8'($urandom_range(249, 255)),
                                      8'($urandom_range(252, 255))};
                    default: ;
                endcase
                if ($urandom_range(7) == 0)
                    data[63:56] = 8'hFF;
                if ($urandom_range(1) == 1)
                    data[6:0] = 7'($urandom_range(3));
                case ($urandom_range(9))
                    0: ;
                    1: base_cp = 24'(cp) + 24'($urandom_range(1, 5000));
                    2: base_cp = 24'($urandom_range(255));
                    default: base_cp = 24'(cp) - 24'($urandom_range(cp < 2000 ? cp : 2000));
                endcase
                data[31:8] = base_cp;
            end
        end
        send_item(v, cp, data);
    endtask

    task automatic run_phase(input int pct, input int count);
        idle_pct = pct;
        repeat (count)
            send_random_item();
    endtask

    initial
    begin
        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_directed();
        run_phase(0, 250);
        run_phase(87, 150);
        run_phase(21, 200);
        run_phase(0, 150);
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (3 * ced_pkg::PIPE_DEPTH + 4)
            @(posedge clk);
        $display("run covered %0d items: every tag at its extremes, then random traffic",
                 items_sent);
        $display("over four idle phases; %0d results compared, %0d mismatches",
                 results_checked, mismatches);
        if (mismatches == 0 && pending == 0)
            $display("** collation_element_decoder: PASSED **");
        else
            $display("** collation_element_decoder: FAILED **");
        $finish;
    end

endmodule

[files.f]
rtl/core/ced_pkg.sv
rtl/core/ced_front.sv
rtl/core/ced_range.sv
rtl/core/ced_implicit.sv
rtl/core/collation_element_decoder.sv
bench/ced_element_checker.sv
bench/tb_top.sv
